// ----- src/next_fit_id_allocator_macros.svh -----
// Assertion helpers for the id allocator. Each expects clk and rst_n in scope.
`ifndef NEXT_FIT_ID_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_ID_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define NFIA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NFIA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/nfia_pkg.sv -----
package nfia_pkg;

    localparam int ID_COUNT_DEF = 1024;
    localparam int ID_W         = 10;
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = 5;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_FREE    = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

// ----- src/next_fit_id_allocator.sv -----
// Next-fit identifier allocator. Slot 0 is reserved; an allocate hands out
// the first free slot at or after the search pointer, wrapping past the top
// back to slot 1, and leaves the pointer on that slot. The used map sits in
// a single-port RAM of 32-bit words and one word is examined per cycle by a
// single find-first-free unit. After reset a clearing pass zeroes every word
// before the first item is taken. A free reads its word, clears the bit and
// writes the word back when it hands out its result (an id beyond the pool
// skips the read and the write); an allocate with no free slot answers full
// with id 0. The next item can be accepted while the previous result waits
// on out_ready.
module next_fit_id_allocator #(
    parameter int ID_COUNT = nfia_pkg::ID_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cmd,
    input  logic [nfia_pkg::ID_W-1:0] free_id,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [nfia_pkg::ID_W-1:0] given_id,
    output logic                     status
);
    import nfia_pkg::*;

    `include "next_fit_id_allocator_macros.svh"

    localparam int WORDS     = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_W    = WIDX_W + BIT_W;
    localparam int VIS_W     = $clog2(WORDS + 1);
    localparam int LAST_BITS = ID_COUNT - (WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE_RD,
        S_SCAN,
        S_FINISH
    } state_t;

    function automatic logic [BIT_W-1:0] first_free(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // used-map RAM
    logic [WORD_BITS-1:0] mem [WORDS];
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    state_t               state_reg,      state_next;
    logic [SLOT_W-1:0]    ptr_reg,        ptr_next;
    logic [WIDX_W-1:0]    cur_reg,        cur_next;
    logic [VIS_W-1:0]     visit_reg,      visit_next;
    logic [BIT_W-1:0]     bit_reg,        bit_next;
    logic                 fin_wr_reg,     fin_wr_next;
    logic [WORD_BITS-1:0] fin_data_reg,   fin_data_next;
    logic [ID_W-1:0]      res_id_reg,     res_id_next;
    logic                 res_status_reg, res_status_next;
    logic                 out_valid_reg,  out_valid_next;
    logic [ID_W-1:0]      given_id_reg,   given_id_next;
    logic                 status_reg,     status_next;

    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] avail;
    logic [BIT_W-1:0]     hit_bit;
    logic [SLOT_W-1:0]    hit_slot;
    logic [WIDX_W-1:0]    nxt_word;
    logic                 fid_in_range;
    logic [SLOT_W-1:0]    fid_slot;

    assign fid_in_range = 32'(free_id) < ID_COUNT;
    assign fid_slot     = SLOT_W'(free_id);
    assign nxt_word     = (cur_reg == LAST_WORD) ? '0 : cur_reg + 1'b1;

    // first pass over the start word looks at and above the pointer,
    // the closing pass over it only below
    always_comb begin
        if (visit_reg == '0) begin
            scan_mask = {WORD_BITS{1'b1}} << ptr_reg[BIT_W-1:0];
        end else if (visit_reg == VIS_W'(WORDS)) begin
            scan_mask = ~({WORD_BITS{1'b1}} << ptr_reg[BIT_W-1:0]);
        end else begin
            scan_mask = {WORD_BITS{1'b1}};
        end
        if (cur_reg == '0) begin
            scan_mask[0] = 1'b0;
        end
        if (cur_reg == LAST_WORD) begin
            scan_mask = scan_mask & LAST_MASK;
        end
    end

    assign avail    = ~rd_data_reg & scan_mask;
    assign hit_bit  = first_free(avail);
    assign hit_slot = {cur_reg, hit_bit};

    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        cur_next        = cur_reg;
        visit_next      = visit_reg;
        bit_next        = bit_reg;
        fin_wr_next     = fin_wr_reg;
        fin_data_next   = fin_data_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        given_id_next   = given_id_reg;
        status_next     = status_reg;
        rd_en           = 1'b0;
        rd_addr         = cur_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = fin_data_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (cur_reg == LAST_WORD) begin
                    cur_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    if (cmd == CMD_FREE) begin
                        res_id_next     = free_id;
                        res_status_next = STATUS_OK;
                        if (fid_in_range) begin
                            rd_en      = 1'b1;
                            rd_addr    = fid_slot[SLOT_W-1:BIT_W];
                            cur_next   = fid_slot[SLOT_W-1:BIT_W];
                            bit_next   = fid_slot[BIT_W-1:0];
                            state_next = S_FREE_RD;
                        end else begin
                            fin_wr_next = 1'b0;
                            state_next  = S_FINISH;
                        end
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_reg[SLOT_W-1:BIT_W];
                        cur_next   = ptr_reg[SLOT_W-1:BIT_W];
                        visit_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_FREE_RD: begin
                fin_data_next = rd_data_reg & ~(WORD_BITS'(1) << bit_reg);
                fin_wr_next   = 1'b1;
                state_next    = S_FINISH;
            end
            S_SCAN: begin
                if (avail != '0) begin
                    fin_data_next   = rd_data_reg | (WORD_BITS'(1) << hit_bit);
                    fin_wr_next     = 1'b1;
                    ptr_next        = hit_slot;
                    res_id_next     = ID_W'(hit_slot);
                    res_status_next = STATUS_OK;
                    state_next      = S_FINISH;
                end else if (visit_reg == VIS_W'(WORDS)) begin
                    fin_wr_next     = 1'b0;
                    res_id_next     = '0;
                    res_status_next = STATUS_FULL;
                    state_next      = S_FINISH;
                end else begin
                    // fetch the following word while this one is checked
                    rd_en      = 1'b1;
                    rd_addr    = nxt_word;
                    cur_next   = nxt_word;
                    visit_next = visit_reg + 1'b1;
                end
            end
            S_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    wr_en          = fin_wr_reg;
                    out_valid_next = 1'b1;
                    given_id_next  = res_id_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= SLOT_W'(1);
            cur_reg       <= '0;
            visit_reg     <= '0;
            fin_wr_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cur_reg       <= cur_next;
            visit_reg     <= visit_next;
            fin_wr_reg    <= fin_wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        bit_reg        <= bit_next;
        fin_data_reg   <= fin_data_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        given_id_reg   <= given_id_next;
        status_reg     <= status_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign given_id  = given_id_reg;
    assign status    = status_reg;

    `NFIA_ASSERT_IMP(a_ptr_range, 1'b1, ptr_reg != '0 && 32'(ptr_reg) < ID_COUNT, "bad pointer")
    `NFIA_ASSERT_IMP(a_full_zero, out_valid && status == STATUS_FULL, given_id == '0, "id on full")
    `NFIA_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "item overlap")
    `NFIA_ASSERT_IMP(a_scan_bound, state_reg == S_SCAN, visit_reg <= VIS_W'(WORDS), "scan overrun")

endmodule

// ----- tb/next_fit_id_allocator_checker.sv -----
module next_fit_id_allocator_checker
    import nfia_pkg::*;
#(
    parameter int ID_COUNT = ID_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic            cmd,
    input  logic [ID_W-1:0] free_id,
    input  logic            out_valid,
    input  logic            out_ready,
    input  logic [ID_W-1:0] given_id,
    input  logic            status,
    output int              fail_count,
    output int              outstanding,
    output int              grants,
    output int              refusals,
    output int              releases
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            stat;
    } id_answer_t;

    logic       slot_taken [ID_COUNT];
    int         hunt_ptr;
    id_answer_t awaited_answers [$];
    int         errors;
    int         n_grant;
    int         n_refuse;
    int         n_release;

    // next-fit search from the kept pointer; slot 0 never handed out
    function automatic id_answer_t serve_request(input logic c, input logic [ID_W-1:0] fid);
        id_answer_t ans;
        int         start;
        int         p;
        ans.id   = fid;
        ans.stat = STATUS_OK;
        if (c == CMD_FREE) begin
            if (int'(fid) < ID_COUNT)
            begin
                slot_taken[fid] = 1'b0;
            end
            return ans;
        end
        if (hunt_ptr < 1 || hunt_ptr >= ID_COUNT)
        begin
            hunt_ptr = 1;
        end
        start = hunt_ptr;
        p     = start;
        do
        begin
            if (!slot_taken[p])
            begin
                slot_taken[p] = 1'b1;
                hunt_ptr      = p;
                ans.id        = p[ID_W-1:0];
                return ans;
            end
            p = (p + 1 >= ID_COUNT) ? 1 : p + 1;
        end while (p != start);
        ans.id   = '0;
        ans.stat = STATUS_FULL;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        id_answer_t exp_ans;
        id_answer_t new_ans;
        if (!rst_n)
        begin
            foreach (slot_taken[i])
            begin
                slot_taken[i] = 1'b0;
            end
            hunt_ptr = 1;
            awaited_answers.delete();
        end
        else
        begin
            // result side first: a result can never belong to the item taken this edge
            if (out_valid && out_ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $error("result with nothing awaited: given_id=%0d status=%0d",
                           given_id, status);
                    errors++;
                end
                else
                begin
                    exp_ans = awaited_answers.pop_front();
                    if (given_id !== exp_ans.id)
                    begin
                        $error("given_id: expected %0d, got %0d", exp_ans.id, given_id);
                        errors++;
                    end
                    if (status !== exp_ans.stat)
                    begin
                        $error("status: expected %0d, got %0d", exp_ans.stat, status);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                new_ans = serve_request(cmd, free_id);
                awaited_answers.push_back(new_ans);
                if (cmd == CMD_FREE)
                begin
                    n_release++;
                end
                else if (new_ans.stat == STATUS_FULL)
                begin
                    n_refuse++;
                end
                else
                begin
                    n_grant++;
                end
            end
        end
        fail_count  <= errors;
        outstanding <= awaited_answers.size();
        grants      <= n_grant;
        refusals    <= n_refuse;
        releases    <= n_release;
    end

endmodule

// ----- tb/next_fit_id_allocator_test.sv -----
module next_fit_id_allocator_test;
    import nfia_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1830;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 600;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} rx_mode_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic            cmd;
    logic [ID_W-1:0] free_id;
    logic            out_valid;
    logic            out_ready;
    logic [ID_W-1:0] given_id;
    logic            status;

    int fail_count;
    int outstanding;
    int grants;
    int refusals;
    int releases;
    int cycles;

    next_fit_id_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .free_id   (free_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .given_id  (given_id),
        .status    (status)
    );

    next_fit_id_allocator_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .free_id     (free_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .given_id    (given_id),
        .status      (status),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .grants      (grants),
        .refusals    (refusals),
        .releases    (releases)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: own stall pattern, plus two long hold-offs to back the block up
    initial
    begin : receiver
        int       rx_cycles;
        int       mode_left;
        int       hold_left;
        rx_mode_t mode;
        out_ready = 1'b0;
        rx_cycles = 0;
        mode_left = 0;
        hold_left = 0;
        mode      = RX_ALWAYS;
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles == 3000 || rx_cycles == 20000)
            begin
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_ALWAYS:      out_ready <= 1'b1;
                    RX_COIN:        out_ready <= 1'($urandom_range(0, 1));
                    RX_ONE_IN_FOUR: out_ready <= (rx_cycles % 4 == 0);
                    default:        out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic offer(input logic c, input logic [ID_W-1:0] id);
        in_valid <= 1'b1;
        cmd      <= c;
        free_id  <= id;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic pause_input(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end while (outstanding != 0);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return ID_W'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int   k;
        int   burst_left;
        int   free_pct;
        logic c;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_ALLOC;
        free_id  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: first grants, double free, free of the reserved slot and the top slot
        offer(CMD_ALLOC, '0);
        offer(CMD_ALLOC, '1);
        offer(CMD_FREE, 10'd1);
        offer(CMD_FREE, 10'd1);
        offer(CMD_FREE, '0);
        offer(CMD_FREE, '1);
        offer(CMD_ALLOC, 10'h155);
        offer(CMD_ALLOC, 10'h2aa);
        offer(CMD_FREE, 10'd2);
        offer(CMD_ALLOC, '0);
        offer(CMD_FREE, 10'd3);
        offer(CMD_FREE, 10'd4);
        offer(CMD_ALLOC, '1);
        offer(CMD_ALLOC, '1);
        offer(CMD_FREE, 10'h200);
        offer(CMD_FREE, 10'h155);
        offer(CMD_ALLOC, 10'h3fe);
        wait_drained();
        offer(CMD_ALLOC, '0);
        offer(CMD_FREE, 10'd1);
        offer(CMD_ALLOC, '0);

        // random: fill past full, then mostly release, then an even mix
        burst_left = 0;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 600 || k == 1300 || $urandom_range(0, 149) == 0)
            begin
                wait_drained();
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                begin
                    pause_input($urandom_range(1, 20));
                end
            end
            burst_left--;
            if (k < 1250)
            begin
                free_pct = 4;
            end
            else if (k < 1600)
            begin
                free_pct = 75;
            end
            else
            begin
                free_pct = 50;
            end
            c = ($urandom_range(0, 99) < free_pct) ? CMD_FREE : CMD_ALLOC;
            offer(c, pick_id());
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Covered %0d grants, %0d pool-full answers and %0d releases in %0d cycles.",
                 grants, refusals, releases, cycles);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/nfia_pkg.sv
src/next_fit_id_allocator.sv
tb/next_fit_id_allocator_checker.sv
tb/next_fit_id_allocator_test.sv
